FILE: design/uoac_pkg.sv
`default_nettype none

package uoac_pkg;

  // Sequencer phases of one ranging and steering cycle.
  typedef enum logic [2:0] {
    PH_TRIG   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_MEAS   = 3'd2,
    PH_BRK1   = 3'd3,
    PH_REV    = 3'd4,
    PH_TURN   = 3'd5,
    PH_BRK2   = 3'd6,
    PH_SETTLE = 3'd7
  } phase_e;

  // Configuration register indexes (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_TRIGGER = 3'd0,
    REG_TIMEOUT = 3'd1,
    REG_NEAR    = 3'd2,
    REG_SLOW    = 3'd3,
    REG_BRAKE   = 3'd4,
    REG_REVERSE = 3'd5,
    REG_TURN    = 3'd6,
    REG_SETTLE  = 3'd7
  } reg_idx_e;

  localparam int unsigned DurWidth   = 19;
  localparam int unsigned WidthBits  = 16;
  localparam int unsigned AddrWidth  = 5;

  // Motor pin patterns: bit 0 right_fwd, 1 right_rev, 2 left_fwd, 3 left_rev.
  localparam logic [3:0] PinsFwd   = 4'h5;
  localparam logic [3:0] PinsRev   = 4'hA;
  localparam logic [3:0] PinsRight = 4'h6;
  localparam logic [3:0] PinsBrake = 4'hF;
  localparam logic [3:0] PinsCoast = 4'h0;

  // Reset values of the configuration registers.
  localparam logic [7:0]          RstTrigger = 8'd10;
  localparam logic [15:0]         RstTimeout = 16'd30000;
  localparam logic [15:0]         RstNear    = 16'd874;
  localparam logic [15:0]         RstSlow    = 16'd1166;
  localparam logic [DurWidth-1:0] RstBrake   = 19'd200000;
  localparam logic [DurWidth-1:0] RstReverse = 19'd400000;
  localparam logic [DurWidth-1:0] RstTurn    = 19'd500000;
  localparam logic [DurWidth-1:0] RstSettle  = 19'd50000;

  typedef struct packed {
    logic [7:0]          trigger_ticks;
    logic [15:0]         echo_timeout;
    logic [15:0]         near_limit;
    logic [15:0]         slow_limit;
    logic [DurWidth-1:0] brake_ticks;
    logic [DurWidth-1:0] reverse_ticks;
    logic [DurWidth-1:0] turn_ticks;
    logic [DurWidth-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 trigger_out;
    logic [3:0]           pins;
    logic                 range_done;
    logic                 range_timeout;
    logic [WidthBits-1:0] echo_ticks;
  } res_t;

endpackage

`default_nettype wire

FILE: design/uoac_apb_regs.sv
`default_nettype none

module uoac_apb_regs
  import uoac_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output cfg_t                      cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TRIGGER: cfg_d.trigger_ticks = pwdata[7:0];
        REG_TIMEOUT: cfg_d.echo_timeout  = pwdata[15:0];
        REG_NEAR:    cfg_d.near_limit    = pwdata[15:0];
        REG_SLOW:    cfg_d.slow_limit    = pwdata[15:0];
        REG_BRAKE:   cfg_d.brake_ticks   = pwdata[DurWidth-1:0];
        REG_REVERSE: cfg_d.reverse_ticks = pwdata[DurWidth-1:0];
        REG_TURN:    cfg_d.turn_ticks    = pwdata[DurWidth-1:0];
        REG_SETTLE:  cfg_d.settle_ticks  = pwdata[DurWidth-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIGGER: prdata = 32'(cfg_q.trigger_ticks);
      REG_TIMEOUT: prdata = 32'(cfg_q.echo_timeout);
      REG_NEAR:    prdata = 32'(cfg_q.near_limit);
      REG_SLOW:    prdata = 32'(cfg_q.slow_limit);
      REG_BRAKE:   prdata = 32'(cfg_q.brake_ticks);
      REG_REVERSE: prdata = 32'(cfg_q.reverse_ticks);
      REG_TURN:    prdata = 32'(cfg_q.turn_ticks);
      REG_SETTLE:  prdata = 32'(cfg_q.settle_ticks);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= RstTrigger;
      cfg_q.echo_timeout  <= RstTimeout;
      cfg_q.near_limit    <= RstNear;
      cfg_q.slow_limit    <= RstSlow;
      cfg_q.brake_ticks   <= RstBrake;
      cfg_q.reverse_ticks <= RstReverse;
      cfg_q.turn_ticks    <= RstTurn;
      cfg_q.settle_ticks  <= RstSettle;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/uoac_core.sv
`default_nettype none

module uoac_core
  import uoac_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 19
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic echo_i,
  input  wire cfg_t cfg_i,
  output res_t      res_o
);

  // Compare width covers both the counter and the 19-bit durations.
  localparam int unsigned CmpW = (COUNT_WIDTH > DurWidth) ? COUNT_WIDTH : DurWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [3:0]             pins_q, pins_d;

  logic [COUNT_WIDTH-1:0] cnt_up;
  logic [DurWidth-1:0]    limit;
  logic                   timed_done;
  logic                   timed_out;
  logic [WidthBits-1:0]   width_sat;
  logic                   decide;
  logic                   tmo;
  logic                   done;
  logic [WidthBits-1:0]   width;

  assign cnt_up = (tick_q == CntMax) ? tick_q : tick_q + 1'b1;

  always_comb begin
    case (phase_q) inside
      PH_TRIG:              limit = DurWidth'(cfg_i.trigger_ticks);
      PH_BRK1, PH_BRK2:     limit = cfg_i.brake_ticks;
      PH_REV:               limit = cfg_i.reverse_ticks;
      PH_TURN:              limit = cfg_i.turn_ticks;
      default:              limit = cfg_i.settle_ticks;
    endcase
  end

  assign timed_done = (CmpW'(cnt_up) >= CmpW'(limit)) || (cnt_up == CntMax);
  assign timed_out  = (CmpW'(tick_q) > CmpW'(cfg_i.echo_timeout)) || (tick_q == CntMax);
  assign width_sat  = (CmpW'(tick_q) > CmpW'({WidthBits{1'b1}})) ? {WidthBits{1'b1}}
                                                                   : tick_q[WidthBits-1:0];

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    pins_d  = pins_q;
    decide  = 1'b0;
    tmo     = 1'b0;
    done    = 1'b0;
    width   = '0;

    unique case (phase_q)
      PH_TRIG: begin
        tick_d = timed_done ? '0 : cnt_up;
        if (timed_done) phase_d = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo_i) begin
          phase_d = PH_MEAS;
          tick_d  = COUNT_WIDTH'(1);
        end else if (timed_out) begin
          done   = 1'b1;
          tmo    = 1'b1;
          decide = 1'b1;
        end else begin
          tick_d = cnt_up;
        end
      end
      PH_MEAS: begin
        if (!echo_i) begin
          done   = 1'b1;
          width  = width_sat;
          decide = 1'b1;
        end else if (timed_out) begin
          done   = 1'b1;
          tmo    = 1'b1;
          decide = 1'b1;
        end else begin
          tick_d = cnt_up;
        end
      end
      PH_BRK1: begin
        tick_d = timed_done ? '0 : cnt_up;
        if (timed_done) begin
          pins_d  = PinsRev;
          phase_d = PH_REV;
        end
      end
      PH_REV: begin
        tick_d = timed_done ? '0 : cnt_up;
        if (timed_done) begin
          pins_d  = PinsRight;
          phase_d = PH_TURN;
        end
      end
      PH_TURN: begin
        tick_d = timed_done ? '0 : cnt_up;
        if (timed_done) begin
          pins_d  = PinsBrake;
          phase_d = PH_BRK2;
        end
      end
      PH_BRK2: begin
        tick_d = timed_done ? '0 : cnt_up;
        if (timed_done) phase_d = PH_SETTLE;
      end
      PH_SETTLE: begin
        tick_d = timed_done ? '0 : cnt_up;
        if (timed_done) phase_d = PH_TRIG;
      end
    endcase

    // A finished measurement picks the next motor command.
    if (decide) begin
      tick_d = '0;
      if (!tmo && (width <= cfg_i.near_limit)) begin
        pins_d  = PinsBrake;
        phase_d = PH_BRK1;
      end else if (!tmo && (width <= cfg_i.slow_limit)) begin
        pins_d  = PinsCoast;
        phase_d = PH_SETTLE;
      end else begin
        pins_d  = PinsFwd;
        phase_d = PH_SETTLE;
      end
    end
  end

  assign res_o.trigger_out   = (phase_q == PH_TRIG);
  assign res_o.pins          = pins_d;
  assign res_o.range_done    = done;
  assign res_o.range_timeout = tmo;
  assign res_o.echo_ticks    = width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TRIG;
      tick_q  <= '0;
      pins_q  <= PinsCoast;
    end else if (adv_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pins_q  <= pins_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ultrasonic_obstacle_avoid_controller.sv
`default_nettype none

// Channel   Direction  Handshake                  Contents
// s_axis    in         tvalid/tready              one 1 us tick with the sampled echo level
// m_axis    out        tvalid/tready              one result per tick: trigger, motor pins,
//                                                 range status and echo width
// apb       in/out     psel/penable/pwrite/pready configuration registers at 4 * index
//
// Each tick request is handled by short combinational logic fed from the sequencer
// state, and its result is captured in the output register.
// One request is accepted per cycle for as long as the output side keeps taking results.
// When the output register is full and not being taken, the input side stalls.
// Reset puts the sequencer in the trigger phase with the motor pins coasting and loads the
// default register values; no clearing pass is needed.

module ultrasonic_obstacle_avoid_controller
  import uoac_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 19
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [0] echo_level, [7:1] zero

  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [0] trigger_out, [1] right_fwd, [2] right_rev, [3] left_fwd, [4] left_rev,
  // [5] range_done, [6] range_timeout, [22:7] echo_ticks, [23] zero
  output logic      [23:0]          m_axis_tdata_o,

  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  cfg_t cfg;
  res_t res;
  res_t out_q;
  logic out_valid_q;
  logic in_fire;

  // The output register frees itself in the same cycle it is taken.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  uoac_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uoac_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_fire),
    .echo_i (s_axis_tdata_i[0]),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.echo_ticks, out_q.range_timeout, out_q.range_done,
                            out_q.pins, out_q.trigger_out};

  // A timed-out measurement is always reported as finished.
  a_tmo_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6] |-> m_axis_tdata_o[5])
    else $error("timeout reported without range_done");

  // A timeout carries no width.
  a_tmo_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6] |-> (m_axis_tdata_o[22:7] == '0))
    else $error("echo width reported on a timeout");

  // Trigger pulse and measurement end never fall on the same tick.
  a_trig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[5]))
    else $error("trigger and range_done on the same tick");

  // An empty output register never blocks the input side.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  // An accepted tick always shows up in the output register next cycle.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid_o)
    else $error("accepted tick produced no result");

endmodule

`default_nettype wire

FILE: dv/tb_ultrasonic_obstacle_avoid_controller.sv
`timescale 1ns / 100ps

module tb_ultrasonic_obstacle_avoid_controller;
  import uoac_pkg::*;

  localparam int unsigned CountWidth = 19;
  localparam logic [CountWidth-1:0] CountMax = '1;
  // Longest legal quiet stretch is a source gap plus a sink stall plus an APB write.
  // The limit is set far above that.
  localparam int unsigned StallLimit = 2000;

  // One expected result, one field per item of the result stream.
  typedef struct packed {
    logic        trigger_out;
    logic        right_fwd;
    logic        right_rev;
    logic        left_fwd;
    logic        left_rev;
    logic        range_done;
    logic        range_timeout;
    logic [15:0] echo_ticks;
  } tick_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  ultrasonic_obstacle_avoid_controller #(
    .COUNT_WIDTH(CountWidth)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // [0] echo_level, [7:1] zero
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    // [0] trigger_out, [4:1] motor pins, [5] range_done, [6] range_timeout,
    // [22:7] echo_ticks, [23] zero
    .m_axis_tdata_o (m_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the sequencer: phase, tick counter, latched motor pins and the register
  // copy that the writes below keep in step with the block.
  phase_e                model_phase = PH_TRIG;
  logic [CountWidth-1:0] model_cnt = '0;
  logic [3:0]            model_pins = PinsCoast;
  cfg_t                  model_cfg = '{
    trigger_ticks: RstTrigger, echo_timeout: RstTimeout, near_limit: RstNear,
    slow_limit: RstSlow, brake_ticks: RstBrake, reverse_ticks: RstReverse,
    turn_ticks: RstTurn, settle_ticks: RstSettle
  };

  tick_result_t tick_results_due[$];
  int unsigned  mismatches = 0;
  int unsigned  ticks_sent = 0;
  bit           no_idle = 1'b0;

  // Pacing for both sides; zero while a stretch without idling is wanted.
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // The tick counter saturates instead of wrapping.
  function automatic logic [CountWidth-1:0] bump(logic [CountWidth-1:0] c);
    return (c == CountMax) ? CountMax : c + 1'b1;
  endfunction

  // Advances a timed phase and tells whether this tick is its last one. A limit of
  // zero still gives one tick, and a saturated counter ends the phase too.
  function automatic bit phase_over(logic [CountWidth-1:0] limit);
    logic [CountWidth-1:0] n;
    n = bump(model_cnt);
    if (n >= limit || n == CountMax) begin
      model_cnt = '0;
      return 1'b1;
    end
    model_cnt = n;
    return 1'b0;
  endfunction

  // Works out the result of one tick and moves the shadow state on.
  function automatic tick_result_t step_ranging(bit echo);
    tick_result_t r;
    bit           decide;
    r = '0;
    decide = 1'b0;
    case (model_phase)
      PH_TRIG: begin
        r.trigger_out = 1'b1;
        if (phase_over(model_cfg.trigger_ticks)) model_phase = PH_WAIT;
      end
      PH_WAIT: begin
        // The first high tick counts as one; a rising echo beats a due timeout.
        if (echo) begin
          model_phase = PH_MEAS;
          model_cnt = 1;
        end else if (model_cnt > model_cfg.echo_timeout || model_cnt == CountMax) begin
          r.range_done = 1'b1;
          r.range_timeout = 1'b1;
          decide = 1'b1;
        end else begin
          model_cnt = bump(model_cnt);
        end
      end
      PH_MEAS: begin
        if (!echo) begin
          // A width beyond the 16-bit field is reported as all ones.
          r.range_done = 1'b1;
          r.echo_ticks = (model_cnt > 16'hFFFF) ? 16'hFFFF : model_cnt[15:0];
          decide = 1'b1;
        end else if (model_cnt > model_cfg.echo_timeout || model_cnt == CountMax) begin
          r.range_done = 1'b1;
          r.range_timeout = 1'b1;
          decide = 1'b1;
        end else begin
          model_cnt = bump(model_cnt);
        end
      end
      PH_BRK1: begin
        if (phase_over(model_cfg.brake_ticks)) begin
          model_pins = PinsRev;
          model_phase = PH_REV;
        end
      end
      PH_REV: begin
        if (phase_over(model_cfg.reverse_ticks)) begin
          model_pins = PinsRight;
          model_phase = PH_TURN;
        end
      end
      PH_TURN: begin
        if (phase_over(model_cfg.turn_ticks)) begin
          model_pins = PinsBrake;
          model_phase = PH_BRK2;
        end
      end
      PH_BRK2: begin
        if (phase_over(model_cfg.brake_ticks)) model_phase = PH_SETTLE;
      end
      default: begin
        if (phase_over(model_cfg.settle_ticks)) model_phase = PH_TRIG;
      end
    endcase

    // A finished measurement picks the motor command: too close starts the avoidance
    // sequence, the middle zone coasts, anything farther or a timeout drives forward.
    if (decide) begin
      model_cnt = '0;
      if (!r.range_timeout && r.echo_ticks <= model_cfg.near_limit) begin
        model_pins = PinsBrake;
        model_phase = PH_BRK1;
      end else if (!r.range_timeout && r.echo_ticks <= model_cfg.slow_limit) begin
        model_pins = PinsCoast;
        model_phase = PH_SETTLE;
      end else begin
        model_pins = PinsFwd;
        model_phase = PH_SETTLE;
      end
    end

    r.right_fwd = model_pins[0];
    r.right_rev = model_pins[1];
    r.left_fwd  = model_pins[2];
    r.left_rev  = model_pins[3];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sends one tick request. The shadow model is stepped right at the accepting edge,
  // so the stimulus below can steer by the phase the next tick will meet.
  task automatic send_tick(input bit echo);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, echo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tick_results_due.push_back(step_ranging(echo));
    ticks_sent++;
  endtask

  // Drops valid and waits on the clock, so no later drive lands in the same step.
  task automatic idle_source();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (tick_results_due.size() != 0) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle; the register takes the value at the
  // edge that closes the access cycle with pready high.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_TRIGGER: model_cfg.trigger_ticks = value[7:0];
      REG_TIMEOUT: model_cfg.echo_timeout  = value[15:0];
      REG_NEAR:    model_cfg.near_limit    = value[15:0];
      REG_SLOW:    model_cfg.slow_limit    = value[15:0];
      REG_BRAKE:   model_cfg.brake_ticks   = value[DurWidth-1:0];
      REG_REVERSE: model_cfg.reverse_ticks = value[DurWidth-1:0];
      REG_TURN:    model_cfg.turn_ticks    = value[DurWidth-1:0];
      default:     model_cfg.settle_ticks  = value[DurWidth-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrites every register once the block is idle. Bits above each register's width
  // carry junk, which the block has to drop.
  task automatic load_config(input cfg_t c);
    logic [31:0] junk;
    idle_source();
    wait_drained();
    junk = $urandom();
    write_reg(REG_TRIGGER, {junk[31:8], c.trigger_ticks});
    junk = $urandom();
    write_reg(REG_TIMEOUT, {junk[31:16], c.echo_timeout});
    junk = $urandom();
    write_reg(REG_NEAR, {junk[31:16], c.near_limit});
    junk = $urandom();
    write_reg(REG_SLOW, {junk[31:16], c.slow_limit});
    junk = $urandom();
    write_reg(REG_BRAKE, {junk[31:DurWidth], c.brake_ticks});
    junk = $urandom();
    write_reg(REG_REVERSE, {junk[31:DurWidth], c.reverse_ticks});
    junk = $urandom();
    write_reg(REG_TURN, {junk[31:DurWidth], c.turn_ticks});
    junk = $urandom();
    write_reg(REG_SETTLE, {junk[31:DurWidth], c.settle_ticks});
  endtask

  // One well-formed ranging cycle: idle ticks until the block listens, dly low ticks,
  // then an echo held high until the measured width reaches w. Either wait may end in
  // a timeout first, which the loops notice from the shadow phase.
  task automatic ping(input int dly, input int w);
    while (model_phase != PH_WAIT) send_tick(1'b0);
    repeat (dly) if (model_phase == PH_WAIT) send_tick(1'b0);
    if (model_phase == PH_WAIT) send_tick(1'b1);
    while (model_phase == PH_MEAS && int'(model_cnt) < w) send_tick(1'b1);
    if (model_phase == PH_MEAS) send_tick(1'b0);
  endtask

  // Reset values: the default trigger pulse of ten ticks, then the start of the wait.
  task automatic test_reset_values();
    repeat (12) send_tick(1'b0);
  endtask

  // Short directed run with tiny limits: zero trigger, brake and settle limits, every
  // motor command, a wait that ends exactly as the echo rises, and both timeouts.
  task automatic test_directed();
    load_config('{trigger_ticks: 8'd0, echo_timeout: 16'd4, near_limit: 16'd1,
                  slow_limit: 16'd2, brake_ticks: '0, reverse_ticks: 19'd1,
                  turn_ticks: 19'd2, settle_ticks: '0});
    ping(0, 1);   // too close: brake, reverse, turn right, brake
    ping(4, 2);   // coasting zone
    ping(5, 3);   // echo rises on the tick the wait would time out; far, forward
    ping(6, 1);   // no echo: wait times out
    ping(0, 9);   // echo stays high: measurement times out
  endtask

  // Random pings around the thresholds, mixed with noise ticks, over several settings.
  task automatic test_random();
    cfg_t c;
    int   seg_end;
    int   dly;
    int   w;
    int   t;
    int   n;
    for (int seg = 0; seg < 6; seg++) begin
      c.trigger_ticks = $urandom_range(1, 6);
      c.echo_timeout  = $urandom_range(8, 120);
      c.near_limit    = $urandom_range(0, c.echo_timeout);
      c.slow_limit    = $urandom_range(c.near_limit, c.echo_timeout + 4);
      c.brake_ticks   = $urandom_range(0, 20);
      c.reverse_ticks = $urandom_range(0, 20);
      c.turn_ticks    = $urandom_range(0, 20);
      c.settle_ticks  = $urandom_range(0, 20);
      no_idle = 1'b0;
      case (seg)
        1: begin
          // Longest trigger pulse with a very short timeout.
          c.trigger_ticks = 8'd255;
          c.echo_timeout  = 16'd1;
          c.near_limit    = 16'd1;
          c.slow_limit    = 16'd2;
        end
        2: begin
          // Every measurement that does not time out starts the avoidance sequence.
          c.near_limit = 16'hFFFF;
          c.slow_limit = '0;
        end
        3: begin
          // Nothing counts as too close; the whole range coasts.
          c.near_limit = '0;
          c.slow_limit = 16'hFFFF;
        end
        4: begin
          // Coasting limit below the near limit.
          c.echo_timeout = 16'd60;
          c.near_limit   = 16'd30;
          c.slow_limit   = 16'd10;
        end
        5: no_idle = 1'b1;
        default: ;
      endcase
      load_config(c);
      seg_end = ticks_sent + 120;
      while (ticks_sent < seg_end) begin
        t = model_cfg.echo_timeout;
        case ($urandom_range(0, 4))
          0:       dly = 0;
          1:       dly = t;
          2:       dly = t + 1;
          3:       dly = t + 2;
          default: dly = $urandom_range(0, t);
        endcase
        case ($urandom_range(0, 8))
          0:       w = 1;
          1:       w = model_cfg.near_limit;
          2:       w = model_cfg.near_limit + 1;
          3:       w = model_cfg.slow_limit;
          4:       w = model_cfg.slow_limit + 1;
          5:       w = t;
          6:       w = t + 1;
          7:       w = t + 2;
          default: w = $urandom_range(1, t + 2);
        endcase
        ping(dly, w);
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 8);
          repeat (n) send_tick($urandom_range(0, 1));
        end
        // Now and then the source holds off until every result is back.
        if ($urandom_range(0, 39) == 0) begin
          idle_source();
          wait_drained();
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Full-range limits, run back to back without idling: the widest timeout with a
  // far reading, then the widest near zone with the longest timed phases, of which
  // only the start of the first brake phase is run.
  task automatic test_full_range();
    no_idle = 1'b1;
    load_config('{trigger_ticks: 8'd0, echo_timeout: 16'hFFFF, near_limit: '0,
                  slow_limit: '0, brake_ticks: '0, reverse_ticks: '0,
                  turn_ticks: '0, settle_ticks: '0});
    ping(0, 70);
    while (model_phase != PH_WAIT) send_tick(1'b0);
    load_config('{trigger_ticks: 8'd255, echo_timeout: 16'hFFFF, near_limit: 16'hFFFF,
                  slow_limit: 16'hFFFF, brake_ticks: '1, reverse_ticks: '1,
                  turn_ticks: '1, settle_ticks: '1});
    ping(3, 40);
    repeat (20) send_tick($urandom_range(0, 1));
    no_idle = 1'b0;
  endtask

  // Result side: every accepted result is checked against the oldest expectation,
  // then a fresh stall is drawn for the next one.
  int sink_hold = 0;

  always @(posedge clk) begin : sink_side
    tick_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (tick_results_due.size() == 0) begin
        $error("result accepted with no tick request pending");
        mismatches++;
      end else begin
        want = tick_results_due.pop_front();
        check_field("trigger_out", want.trigger_out, m_tdata[0]);
        check_field("right_fwd", want.right_fwd, m_tdata[1]);
        check_field("right_rev", want.right_rev, m_tdata[2]);
        check_field("left_fwd", want.left_fwd, m_tdata[3]);
        check_field("left_rev", want.left_rev, m_tdata[4]);
        check_field("range_done", want.range_done, m_tdata[5]);
        check_field("range_timeout", want.range_timeout, m_tdata[6]);
        check_field("echo_ticks", want.echo_ticks, m_tdata[22:7]);
      end
      sink_hold = draw_gap();
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: ends the run when nothing moves on any port for too long.
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_random();
    test_full_range();

    idle_source();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/uoac_pkg.sv
design/uoac_apb_regs.sv
design/uoac_core.sv
design/ultrasonic_obstacle_avoid_controller.sv
dv/tb_ultrasonic_obstacle_avoid_controller.sv
